// ===== src/tspg_pkg.sv =====
// Shared types and constants for the trapezoid step pulse generator.
// Used by tspg_motor and trapezoid_step_pulse_generator_top.
package tspg_pkg;

  localparam int MASK_W = 6;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_HALT  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // control from the block sequencer to one motor
  typedef struct packed {
    logic load;
    logic tick;
    logic halt;
  } motor_ctrl_t;

  // status from one motor back to the sequencer
  typedef struct packed {
    logic active;   // target still non-zero
    logic step;     // stepped on this tick
    logic finish;   // motor stops on this tick
  } motor_stat_t;

endpackage

// ===== src/tspg_motor.sv =====
// One motor channel: rate profile, phase accumulator and step counting.
// Depends on tspg_pkg for the control and status structs.
module tspg_motor import tspg_pkg::*; #(
  parameter int FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  motor_ctrl_t        ctrl,
  input  logic               moving,
  input  logic [31:0]        tick_now,
  input  logic [31:0]        accel_end,
  input  logic [31:0]        decel_start,
  input  logic [31:0]        total_ticks,
  input  logic [31:0]        ld_steps,
  input  logic [31:0]        ld_rate,
  input  logic [31:0]        ld_accel,
  input  logic [31:0]        ld_decel,
  input  logic [30:0]        ld_cruise,
  input  logic [31:0]        ld_event,
  output motor_stat_t        stat
);

  localparam logic [31:0] ONE_STEP = 32'(1) << FRAC_BITS;

  logic [31:0] target_r,   target_nxt;
  logic [31:0] issued_r,   issued_nxt;
  logic [31:0] rate_r,     rate_nxt;
  logic [31:0] rchg_r,     rchg_nxt;
  logic [31:0] dchg_r,     dchg_nxt;
  logic [30:0] cruise_r,   cruise_nxt;
  logic [31:0] event_r,    event_nxt;
  logic [31:0] acc_r,      acc_nxt;

  logic [31:0] rate_add;
  logic [31:0] acc_base;
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic [31:0] issued_inc;
  logic        step;
  logic        finish;

  always_comb begin
    target_nxt = target_r;
    issued_nxt = issued_r;
    rate_nxt   = rate_r;
    rchg_nxt   = rchg_r;
    dchg_nxt   = dchg_r;
    cruise_nxt = cruise_r;
    event_nxt  = event_r;
    acc_nxt    = acc_r;
    step       = 1'b0;
    finish     = 1'b0;

    // tick path
    rate_add = rate_r + rchg_r;
    if (tick_now == event_r) begin
      if (tick_now == accel_end) begin
        rchg_nxt = '0;
        if (decel_start < total_ticks) begin
          event_nxt = decel_start;
          if (tick_now != decel_start) begin
            rate_add = {1'b0, cruise_r};
          end
        end
      end
      if (tick_now == decel_start) begin
        rchg_nxt = dchg_r;
      end
    end
    acc_base = acc_r;
    // non-positive rate: clamp and force a step
    if (rate_add == '0 || rate_add[31]) begin
      acc_base = ONE_STEP;
      rate_add = '0;
    end
    acc_sum    = {1'b0, acc_base} + {1'b0, rate_add};
    acc_sat    = acc_sum[32] ? '1 : acc_sum[31:0];
    issued_inc = issued_r + 32'd1;

    if (ctrl.tick && target_r != '0) begin
      rate_nxt = rate_add;
      acc_nxt  = acc_sat;
      if (acc_sat >= ONE_STEP) begin
        acc_nxt    = acc_sat - ONE_STEP;
        issued_nxt = issued_inc;
        step       = 1'b1;
        if (!moving || issued_inc == target_r) begin
          target_nxt = '0;
          finish     = 1'b1;
        end
      end
    end else begin
      rchg_nxt  = rchg_r;
      event_nxt = event_r;
    end

    if (ctrl.load) begin
      target_nxt = ld_steps;
      rate_nxt   = ld_rate;
      rchg_nxt   = ld_accel;
      dchg_nxt   = ld_decel;
      cruise_nxt = ld_cruise;
      event_nxt  = ld_event;
      issued_nxt = '0;
      acc_nxt    = '0;
    end

    if (ctrl.halt) begin
      target_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      issued_r <= '0;
      rate_r   <= '0;
      rchg_r   <= '0;
      dchg_r   <= '0;
      cruise_r <= '0;
      event_r  <= '0;
      acc_r    <= '0;
    end else begin
      target_r <= target_nxt;
      issued_r <= issued_nxt;
      rate_r   <= rate_nxt;
      rchg_r   <= rchg_nxt;
      dchg_r   <= dchg_nxt;
      cruise_r <= cruise_nxt;
      event_r  <= event_nxt;
      acc_r    <= acc_nxt;
    end
  end

  assign stat.active = (target_r != '0);
  assign stat.step   = step;
  assign stat.finish = finish;

endmodule

// ===== src/trapezoid_step_pulse_generator_top.sv =====
// Top level of the trapezoid step pulse generator.
// Depends on tspg_pkg and instantiates one tspg_motor per motor.
//
// Usage:
//   Items enter on the in_ valid/ready channel: load a motor slot, start the
//   block, tick, halt, or stop one motor externally. Every item gives exactly
//   one result on the out_ valid/ready channel: step, direction and moving
//   masks, the running flag and a block-done flag.
//   An accepted item fills the input register and then, once no stall holds
//   it there, loads the result register, which drives out_valid.
//   Throughput, without stalls, is one item per cycle; all motors update in
//   parallel, each with one rate adder, one saturating accumulator adder and
//   the event tick compares between the input and result registers.
//   When the receiver holds out_ready low, the result register holds, the
//   input register fills and then in_ready drops; nothing is lost.
//   Synchronous active-low reset clears all motor state, the masks, the
//   tick counter and both valid flags; the block comes up idle.
//   Mask bits at and above MOTOR_COUNT always read as zero.
module trapezoid_step_pulse_generator_top import tspg_pkg::*; #(
  parameter int MOTOR_COUNT = 6,
  parameter int FRAC_BITS   = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [2:0]         in_motor,
  input  logic               in_direction,
  input  logic [31:0]        in_steps_to_move,
  input  logic signed [31:0] in_initial_rate,
  input  logic signed [31:0] in_accel_change,
  input  logic signed [31:0] in_decel_change,
  input  logic [30:0]        in_plateau_rate,
  input  logic [31:0]        in_first_event_tick,
  input  logic [31:0]        in_accel_end_tick,
  input  logic [31:0]        in_decel_start_tick,
  input  logic [31:0]        in_total_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MASK_W-1:0]  out_step_mask,
  output logic [MASK_W-1:0]  out_direction_mask,
  output logic [MASK_W-1:0]  out_moving_mask,
  output logic               out_running,
  output logic               out_block_done
);

  // input register
  logic        item_valid_r;
  logic [2:0]  op_r;
  logic [2:0]  motor_r;
  logic        dir_r;
  logic [31:0] steps_r;
  logic [31:0] irate_r;
  logic [31:0] achg_r;
  logic [31:0] dchg_r;
  logic [30:0] plat_r;
  logic [31:0] fev_r;
  logic [31:0] aend_r;
  logic [31:0] dstart_r;
  logic [31:0] total_r;

  // block state
  logic [31:0]            bpt_aend_r, bpt_aend_nxt;
  logic [31:0]            bpt_dstart_r, bpt_dstart_nxt;
  logic [31:0]            bpt_total_r, bpt_total_nxt;
  logic [31:0]            tick_r, tick_nxt;
  logic                   busy_r, busy_nxt;
  logic [MOTOR_COUNT-1:0] dir_bits_r, dir_bits_nxt;
  logic [MOTOR_COUNT-1:0] mov_bits_r, mov_bits_nxt;
  logic [MOTOR_COUNT-1:0] blk_dir_r, blk_dir_nxt;

  // result register
  logic                   out_valid_r;
  logic [MOTOR_COUNT-1:0] step_r, step_nxt;
  logic [MOTOR_COUNT-1:0] odir_r;
  logic [MOTOR_COUNT-1:0] omov_r;
  logic                   orun_r;
  logic                   odone_r, done_nxt;

  logic stall;
  logic fire;
  logic motor_ok;
  logic is_load, is_start, is_tick, is_halt, is_stop;

  motor_ctrl_t            mctrl [MOTOR_COUNT];
  motor_stat_t            mstat [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] active_vec;
  logic [MOTOR_COUNT-1:0] step_vec;
  logic [MOTOR_COUNT-1:0] finish_vec;
  logic [MOTOR_COUNT-1:0] motor_onehot;

  assign stall    = out_valid_r && !out_ready;
  assign in_ready = !item_valid_r || !stall;
  assign fire     = item_valid_r && !stall;

  assign motor_ok = ({29'd0, motor_r} < MOTOR_COUNT);
  assign is_load  = fire && (op_r == OP_LOAD)  && !busy_r;
  assign is_start = fire && (op_r == OP_START) && !busy_r;
  assign is_tick  = fire && (op_r == OP_TICK)  && busy_r;
  assign is_halt  = fire && (op_r == OP_HALT);
  assign is_stop  = fire && (op_r == OP_STOP)  && motor_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r     <= in_operation;
      motor_r  <= in_motor;
      dir_r    <= in_direction;
      steps_r  <= in_steps_to_move;
      irate_r  <= in_initial_rate;
      achg_r   <= in_accel_change;
      dchg_r   <= in_decel_change;
      plat_r   <= in_plateau_rate;
      fev_r    <= in_first_event_tick;
      aend_r   <= in_accel_end_tick;
      dstart_r <= in_decel_start_tick;
      total_r  <= in_total_ticks;
    end
  end

  genvar m;
  generate
    for (m = 0; m < MOTOR_COUNT; m++) begin : g_motor
      assign motor_onehot[m] = motor_ok && (motor_r == 3'(m));
      assign mctrl[m].load   = is_load && motor_onehot[m];
      assign mctrl[m].tick   = is_tick;
      assign mctrl[m].halt   = is_halt;

      tspg_motor #(
        .FRAC_BITS(FRAC_BITS)
      ) u_motor (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mctrl[m]),
        .moving      (mov_bits_r[m]),
        .tick_now    (tick_r),
        .accel_end   (bpt_aend_r),
        .decel_start (bpt_dstart_r),
        .total_ticks (bpt_total_r),
        .ld_steps    (steps_r),
        .ld_rate     (irate_r),
        .ld_accel    (achg_r),
        .ld_decel    (dchg_r),
        .ld_cruise   (plat_r),
        .ld_event    (fev_r),
        .stat        (mstat[m])
      );

      assign active_vec[m] = mstat[m].active;
      assign step_vec[m]   = mstat[m].step;
      assign finish_vec[m] = mstat[m].finish;
    end
  endgenerate

  always_comb begin
    bpt_aend_nxt   = bpt_aend_r;
    bpt_dstart_nxt = bpt_dstart_r;
    bpt_total_nxt  = bpt_total_r;
    tick_nxt       = tick_r;
    busy_nxt       = busy_r;
    dir_bits_nxt   = dir_bits_r;
    mov_bits_nxt   = mov_bits_r;
    blk_dir_nxt    = blk_dir_r;
    step_nxt       = '0;
    done_nxt       = 1'b0;

    if (is_load) begin
      bpt_aend_nxt   = aend_r;
      bpt_dstart_nxt = dstart_r;
      bpt_total_nxt  = total_r;
      blk_dir_nxt    = (blk_dir_r & ~motor_onehot) | (motor_onehot & {MOTOR_COUNT{dir_r}});
    end

    if (is_start) begin
      dir_bits_nxt = (dir_bits_r & ~active_vec) | (blk_dir_r & active_vec);
      mov_bits_nxt = mov_bits_r | active_vec;
      tick_nxt     = '0;
      if (active_vec != '0) begin
        busy_nxt = 1'b1;
      end else begin
        done_nxt = 1'b1;   // empty block is discarded
      end
    end

    if (is_tick) begin
      step_nxt     = step_vec;
      mov_bits_nxt = mov_bits_r & ~finish_vec;
      if ((mov_bits_nxt & active_vec) != '0) begin
        tick_nxt = tick_r + 32'd1;
      end else begin
        tick_nxt = '0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end

    if (is_halt) begin
      busy_nxt     = 1'b0;
      tick_nxt     = '0;
      mov_bits_nxt = '0;
    end

    if (is_stop) begin
      mov_bits_nxt = mov_bits_r & ~motor_onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpt_aend_r   <= '0;
      bpt_dstart_r <= '0;
      bpt_total_r  <= '0;
      tick_r       <= '0;
      busy_r       <= 1'b0;
      dir_bits_r   <= '0;
      mov_bits_r   <= '0;
      blk_dir_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      bpt_aend_r   <= bpt_aend_nxt;
      bpt_dstart_r <= bpt_dstart_nxt;
      bpt_total_r  <= bpt_total_nxt;
      tick_r       <= tick_nxt;
      busy_r       <= busy_nxt;
      dir_bits_r   <= dir_bits_nxt;
      mov_bits_r   <= mov_bits_nxt;
      blk_dir_r    <= blk_dir_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_r  <= step_nxt;
      odir_r  <= dir_bits_nxt;
      omov_r  <= mov_bits_nxt;
      orun_r  <= busy_nxt;
      odone_r <= done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_mask      = MASK_W'(step_r);
  assign out_direction_mask = MASK_W'(odir_r);
  assign out_moving_mask    = MASK_W'(omov_r);
  assign out_running        = orun_r;
  assign out_block_done     = odone_r;

endmodule

// ===== dv/tspg_result_checker.sv =====
// Result checker for the trapezoid step pulse generator: keeps its own copy of the
// motor and block state, predicts one status result per accepted item and compares.
// Depends on tspg_pkg; instantiated beside the block by tb_trapezoid_step_pulse_generator_top.
module tspg_result_checker import tspg_pkg::*; #(
  parameter int MOTOR_COUNT = 6,
  parameter int FRAC_BITS   = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [2:0]         in_motor,
  input  logic               in_direction,
  input  logic [31:0]        in_steps_to_move,
  input  logic signed [31:0] in_initial_rate,
  input  logic signed [31:0] in_accel_change,
  input  logic signed [31:0] in_decel_change,
  input  logic [30:0]        in_plateau_rate,
  input  logic [31:0]        in_first_event_tick,
  input  logic [31:0]        in_accel_end_tick,
  input  logic [31:0]        in_decel_start_tick,
  input  logic [31:0]        in_total_ticks,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [MASK_W-1:0]  out_step_mask,
  input  logic [MASK_W-1:0]  out_direction_mask,
  input  logic [MASK_W-1:0]  out_moving_mask,
  input  logic               out_running,
  input  logic               out_block_done,
  output int unsigned        error_count,
  output int unsigned        results_outstanding,
  output logic               model_busy
);

  localparam logic [31:0] ONE_STEP = 32'd1 << FRAC_BITS;

  typedef struct {
    logic [MASK_W-1:0] step_mask;
    logic [MASK_W-1:0] direction_mask;
    logic [MASK_W-1:0] moving_mask;
    logic              running;
    logic              block_done;
  } status_t;

  status_t     status_q[$];
  int unsigned results_seen;

  logic [31:0] target_steps [MOTOR_COUNT];
  logic [31:0] issued       [MOTOR_COUNT];
  logic [31:0] motor_rate   [MOTOR_COUNT];
  logic [31:0] rate_delta   [MOTOR_COUNT];
  logic [31:0] decel_delta  [MOTOR_COUNT];
  logic [31:0] cruise_rate  [MOTOR_COUNT];
  logic [31:0] event_tick   [MOTOR_COUNT];
  logic [31:0] accum        [MOTOR_COUNT];
  logic [MASK_W-1:0] dir_shadow, moving_bits, pending_dir;
  logic [31:0] phase_accel_end, phase_decel_start, phase_total;
  logic [31:0] tick_ctr;
  logic        run_active;

  initial begin
    error_count         = 0;
    results_outstanding = 0;
    results_seen        = 0;
    model_busy          = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v)
      flag_error($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                           results_seen, name, exp_v, got_v));
  endtask

  // Advances the shadow state by the item on the input ports and returns its status.
  task automatic predict_status(output status_t st);
    logic [MASK_W-1:0] stepped;
    logic              done, armed, still;
    logic [31:0]       t;
    logic [32:0]       sum;
    stepped = '0;
    done    = 1'b0;
    case (in_operation)
      OP_LOAD: begin
        if (!run_active) begin
          phase_accel_end   = in_accel_end_tick;
          phase_decel_start = in_decel_start_tick;
          phase_total       = in_total_ticks;
          if (in_motor < MOTOR_COUNT) begin
            target_steps[in_motor] = in_steps_to_move;
            motor_rate[in_motor]   = in_initial_rate;
            rate_delta[in_motor]   = in_accel_change;
            decel_delta[in_motor]  = in_decel_change;
            cruise_rate[in_motor]  = {1'b0, in_plateau_rate};
            event_tick[in_motor]   = in_first_event_tick;
            issued[in_motor]       = '0;
            accum[in_motor]        = '0;
            pending_dir[in_motor]  = in_direction;
          end
        end
      end
      OP_START: begin
        if (!run_active) begin
          armed = 1'b0;
          for (int m = 0; m < MOTOR_COUNT; m++) begin
            if (target_steps[m] != '0) begin
              armed          = 1'b1;
              dir_shadow[m]  = pending_dir[m];
              moving_bits[m] = 1'b1;
            end
          end
          tick_ctr = '0;
          if (armed) run_active = 1'b1;
          else done = 1'b1;
        end
      end
      OP_TICK: begin
        if (run_active) begin
          t     = tick_ctr;
          still = 1'b0;
          for (int m = 0; m < MOTOR_COUNT; m++) begin
            if (target_steps[m] != '0) begin
              motor_rate[m] += rate_delta[m];
              if (t == event_tick[m]) begin
                if (t == phase_accel_end) begin
                  rate_delta[m] = '0;
                  if (phase_decel_start < phase_total) begin
                    event_tick[m] = phase_decel_start;
                    if (t != phase_decel_start) motor_rate[m] = cruise_rate[m];
                  end
                end
                if (t == phase_decel_start) rate_delta[m] = decel_delta[m];
              end
              // non-positive rate: clamp and force a step on this tick
              if (motor_rate[m] == '0 || motor_rate[m][31]) begin
                accum[m]      = ONE_STEP;
                motor_rate[m] = '0;
              end
              sum      = {1'b0, accum[m]} + {1'b0, motor_rate[m]};
              accum[m] = sum[32] ? '1 : sum[31:0];
              if (accum[m] >= ONE_STEP) begin
                accum[m]   -= ONE_STEP;
                issued[m]  += 1;
                stepped[m]  = 1'b1;
                if (!moving_bits[m] || issued[m] == target_steps[m]) begin
                  target_steps[m] = '0;
                  moving_bits[m]  = 1'b0;
                end
              end
              if (moving_bits[m]) still = 1'b1;
            end
          end
          tick_ctr += 1;
          if (!still) begin
            tick_ctr   = '0;
            run_active = 1'b0;
          end
          done = !run_active;
        end
      end
      OP_HALT: begin
        run_active  = 1'b0;
        tick_ctr    = '0;
        moving_bits = '0;
        for (int m = 0; m < MOTOR_COUNT; m++) target_steps[m] = '0;
      end
      OP_STOP: begin
        if (in_motor < MOTOR_COUNT) moving_bits[in_motor] = 1'b0;
      end
      default: ;
    endcase
    st.step_mask      = stepped;
    st.direction_mask = dir_shadow;
    st.moving_mask    = moving_bits;
    st.running        = run_active;
    st.block_done     = done;
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        target_steps[m] = '0;
        issued[m]       = '0;
        motor_rate[m]   = '0;
        rate_delta[m]   = '0;
        decel_delta[m]  = '0;
        cruise_rate[m]  = '0;
        event_tick[m]   = '0;
        accum[m]        = '0;
      end
      dir_shadow        = '0;
      moving_bits       = '0;
      pending_dir       = '0;
      phase_accel_end   = '0;
      phase_decel_start = '0;
      phase_total       = '0;
      tick_ctr          = '0;
      run_active        = 1'b0;
      status_q.delete();
    end else begin
      // results leave only after their item has passed the input and result registers, so check before queueing
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no item waiting", results_seen));
        end else begin
          want = status_q.pop_front();
          compare_field("step_mask", 32'(want.step_mask), 32'(out_step_mask));
          compare_field("direction_mask", 32'(want.direction_mask),
                        32'(out_direction_mask));
          compare_field("moving_mask", 32'(want.moving_mask), 32'(out_moving_mask));
          compare_field("running", 32'(want.running), 32'(out_running));
          compare_field("block_done", 32'(want.block_done), 32'(out_block_done));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        predict_status(want);
        status_q.push_back(want);
      end
    end
    results_outstanding <= status_q.size();
    model_busy          <= run_active;
  end

endmodule

// ===== dv/tb_trapezoid_step_pulse_generator_top.sv =====
// Testbench top for the trapezoid step pulse generator: clock, reset, item stimulus,
// result back-pressure, watchdog and verdict. Depends on tspg_pkg, the block's top
// level and tspg_result_checker, which does the prediction and comparison.
module tb_trapezoid_step_pulse_generator_top;
  import tspg_pkg::*;

  localparam int          MOTOR_COUNT    = 6;
  localparam int          FRAC_BITS      = 30;
  localparam logic [31:0] ONE_STEP       = 32'd1 << FRAC_BITS;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
  localparam int          RESET_CYCLES   = 4;
  localparam int          MAX_GAP        = 17;
  localparam int          RANDOM_ITEMS   = 600;
  localparam int          TICK_CAP       = 250;
  localparam int          WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [2:0]  op;
    logic [2:0]  motor;
    logic        dir;
    logic [31:0] steps;
    logic [31:0] init_rate;
    logic [31:0] accel;
    logic [31:0] decel;
    logic [30:0] plateau;
    logic [31:0] first_evt;
    logic [31:0] accel_end;
    logic [31:0] decel_start;
    logic [31:0] total;
  } cmd_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_operation;
  logic [2:0]         in_motor;
  logic               in_direction;
  logic [31:0]        in_steps_to_move;
  logic signed [31:0] in_initial_rate;
  logic signed [31:0] in_accel_change;
  logic signed [31:0] in_decel_change;
  logic [30:0]        in_plateau_rate;
  logic [31:0]        in_first_event_tick;
  logic [31:0]        in_accel_end_tick;
  logic [31:0]        in_decel_start_tick;
  logic [31:0]        in_total_ticks;
  logic               out_valid;
  logic               out_ready;
  logic [MASK_W-1:0]  out_step_mask;
  logic [MASK_W-1:0]  out_direction_mask;
  logic [MASK_W-1:0]  out_moving_mask;
  logic               out_running;
  logic               out_block_done;

  int unsigned check_errors;
  int unsigned results_outstanding;
  logic        model_busy;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;
  bit          fast_sender = 1'b0;

  trapezoid_step_pulse_generator_top #(
    .MOTOR_COUNT(MOTOR_COUNT),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (.*);

  tspg_result_checker #(
    .MOTOR_COUNT(MOTOR_COUNT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .*,
    .error_count        (check_errors),
    .results_outstanding(results_outstanding),
    .model_busy         (model_busy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cmd_t op_cmd(input logic [2:0] op, input logic [2:0] motor);
    cmd_t c;
    c = '{op: op, motor: motor, default: '0};
    return c;
  endfunction

  function automatic cmd_t load_cmd(input logic [2:0] motor, input logic dir,
                                    input logic [31:0] steps, input logic [31:0] init_rate,
                                    input logic [31:0] accel, input logic [31:0] decel,
                                    input logic [30:0] plateau, input logic [31:0] first_evt,
                                    input logic [31:0] accel_end,
                                    input logic [31:0] decel_start,
                                    input logic [31:0] total);
    cmd_t c;
    c.op          = OP_LOAD;
    c.motor       = motor;
    c.dir         = dir;
    c.steps       = steps;
    c.init_rate   = init_rate;
    c.accel       = accel;
    c.decel       = decel;
    c.plateau     = plateau;
    c.first_evt   = first_evt;
    c.accel_end   = accel_end;
    c.decel_start = decel_start;
    c.total       = total;
    return c;
  endfunction

  function automatic cmd_t noise_cmd();
    return load_cmd(3'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom,
                    31'($urandom), $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic drive_fields(input cmd_t c);
    in_operation        <= c.op;
    in_motor            <= c.motor;
    in_direction        <= c.dir;
    in_steps_to_move    <= c.steps;
    in_initial_rate     <= c.init_rate;
    in_accel_change     <= c.accel;
    in_decel_change     <= c.decel;
    in_plateau_rate     <= c.plateau;
    in_first_event_tick <= c.first_evt;
    in_accel_end_tick   <= c.accel_end;
    in_decel_start_tick <= c.decel_start;
    in_total_ticks      <= c.total;
  endtask

  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    gap = fast_sender ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive_fields(c);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off the sender until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  // One well-formed motion block: loads, start, then mostly ticks until the block ends or TICK_CAP is hit.
  task automatic run_block(input bit must_drain);
    int unsigned n_motors, ticks, dice, a_end, d_start, tot;
    cmd_t        c;
    fast_sender = ($urandom_range(0, 3) == 0);
    a_end    = $urandom_range(0, 10);
    dice     = $urandom_range(0, 9);
    d_start  = (dice == 0) ? $urandom_range(0, a_end) : a_end + $urandom_range(0, 15);
    tot      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, d_start)
                                           : d_start + $urandom_range(1, 10);
    n_motors = $urandom_range(1, MOTOR_COUNT);
    repeat (n_motors) begin
      c = load_cmd('0, 1'($urandom), '0, '0, '0, '0, '0, '0, a_end, d_start, tot);
      c.motor = ($urandom_range(0, 19) == 0) ? 3'(MOTOR_COUNT + $urandom_range(0, 1))
                                             : 3'($urandom_range(0, MOTOR_COUNT - 1));
      dice    = $urandom_range(0, 19);
      c.steps = (dice == 0) ? '0 : (dice == 1) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      c.init_rate = ($urandom_range(0, 9) == 0) ? -$urandom_range(0, ONE_STEP)
                                                : $urandom_range(ONE_STEP / 16, ONE_STEP);
      c.accel   = $urandom_range(0, ONE_STEP / 16) - ONE_STEP / 32;
      c.decel   = -$urandom_range(0, ONE_STEP / 16);
      c.plateau = 31'($urandom_range(ONE_STEP / 8, ONE_STEP));
      dice      = $urandom_range(0, 19);
      c.first_evt = (dice < 14) ? a_end : (dice < 17) ? d_start : $urandom_range(0, 20);
      if ($urandom_range(0, 9) == 0) c.total = $urandom_range(0, 30);
      send_cmd(c);
      items_sent++;
    end
    if (must_drain || $urandom_range(0, 4) == 0) drain_results();
    send_cmd(op_cmd(OP_START, '0));
    items_sent++;
    // model_busy trails by one item, so the loop always sends at least one item after the start
    ticks = 0;
    do begin
      dice = $urandom_range(0, 99);
      if (dice < 4)       send_cmd(op_cmd(OP_STOP, 3'($urandom)));
      else if (dice == 4) send_cmd(op_cmd(OP_HALT, '0));
      else if (dice == 5) send_cmd(op_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                                          '0));
      else if (dice == 6) send_cmd(op_cmd(OP_START, '0));
      else if (dice == 7) send_cmd(noise_cmd());
      else begin
        send_cmd(op_cmd(OP_TICK, '0));
        ticks++;
      end
      items_sent++;
    end while (model_busy && ticks < TICK_CAP);
    if (ticks >= TICK_CAP) send_cmd(op_cmd(OP_HALT, '0));
  endtask

  initial begin
    int unsigned n_noise;
    in_valid <= 1'b0;
    drive_fields(op_cmd(OP_LOAD, '0));
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle corner cases first
    send_cmd(op_cmd(OP_TICK, '0));
    send_cmd(op_cmd(OP_START, '0));             // empty block, discarded
    send_cmd(op_cmd(OP_SPARE_FIRST, '0));
    send_cmd(op_cmd(OP_SPARE_FIRST + 3'd1, '0));
    send_cmd(op_cmd(OP_SPARE_LAST, '0));
    send_cmd(op_cmd(OP_STOP, 3'd7));
    send_cmd(op_cmd(OP_STOP, 3'd2));
    send_cmd(load_cmd(3'd7, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    // motor 0 starts negative and wraps: it steps on every tick
    send_cmd(load_cmd(3'd0, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd5));
    send_cmd(load_cmd(3'd1, 1'b0, 32'd3, ONE_STEP / 2, ONE_STEP / 8, -(ONE_STEP / 8),
                      31'(ONE_STEP), 32'd1, 32'd1, 32'd2, 32'd5));
    send_cmd(load_cmd(3'd5, 1'b1, 32'd1, 32'h7FFF_FFFF, '0, '0, '0, '0,
                      32'd1, 32'd2, 32'd5));
    send_cmd(op_cmd(OP_START, '0));
    send_cmd(load_cmd(3'd2, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1));  // ignored
    send_cmd(op_cmd(OP_START, '0));                                      // ignored
    send_cmd(op_cmd(OP_TICK, '0));
    send_cmd(op_cmd(OP_TICK, '0));
    send_cmd(op_cmd(OP_STOP, 3'd0));
    repeat (4) send_cmd(op_cmd(OP_TICK, '0));
    send_cmd(op_cmd(OP_HALT, '0));
    send_cmd(op_cmd(OP_HALT, '0));

    run_block(1'b1);
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        fast_sender = ($urandom_range(0, 3) == 0);
        n_noise = $urandom_range(1, 6);
        repeat (n_noise) send_cmd(noise_cmd());
        send_cmd(op_cmd(OP_HALT, '0));
      end else begin
        run_block(1'b0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (check_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result side back-pressure, with occasional stretches of constant readiness
  initial begin
    int unsigned stall;
    bit          burst;
    burst = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      stall = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
